FILE: rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own logic.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/alrds_pkg.sv
// Package for the absolute log return difference deviation block.
// Holds payload word types, the series summary type and shared constants.
`timescale 1ns / 1ps
`default_nettype none
package alrds_pkg;

   localparam int PRICE_W           = 32;
   localparam int LOG_W             = 32;
   localparam int CNT_W             = 17;
   localparam int SUM_W             = 50;
   localparam int MAG_W             = SUM_W - 1;
   localparam int HALF_W            = (MAG_W + 1) / 2;
   localparam int SQSUM_W           = 56;
   localparam int SQ_DROP           = 14;
   localparam int SQ_W              = 64 - SQ_DROP;
   localparam int MIN_DIFFS         = 3;
   localparam int DEF_MAX_LEN       = 4096;
   localparam int DEF_LOG_FRAC_BITS = 24;
   localparam logic [27:0] LN2_Q28  = 28'd186065280;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic               price_valid;
      logic               last;
   } req_word_type;

   typedef struct packed {
      logic [31:0] std_dev;
      logic        defined;
      logic        overflow;
   } rsp_word_type;

   // Totals of one finished series, handed from the front to the back part.
   typedef struct packed {
      logic [CNT_W-1:0]        cnt;
      logic signed [SUM_W-1:0] sum;
      logic [SQSUM_W-1:0]      sqsum;
      logic                    ovf;
   } summary_type;

endpackage
`default_nettype wire

FILE: rtl/alrds_log_unit.sv
// Iterative natural logarithm of an unsigned Q16.16 price, one squaring per cycle.
// Depends on alrds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module alrds_log_unit #(
   parameter int LOG_FRAC_BITS = alrds_pkg::DEF_LOG_FRAC_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [alrds_pkg::PRICE_W-1:0] price,
   output logic                            done,
   output logic signed [alrds_pkg::LOG_W-1:0] ln_out
);
   import alrds_pkg::*;

   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_SQR  = 2'd1;
   localparam logic [1:0] L_MUL  = 2'd2;
   localparam logic [1:0] L_RND  = 2'd3;
   localparam int ITER_N = 30;
   localparam int RND_SH = 58 - LOG_FRAC_BITS;
   localparam logic [63:0] RND_ADD = 64'(1) << (57 - LOG_FRAC_BITS);

   logic [1:0]  state_ff, state_in;
   logic [4:0]  iter_ff, iter_in;
   logic [31:0] m_ff, m_in;
   logic [29:0] frac_ff, frac_in;
   logic [4:0]  k_ff, k_in;
   logic [62:0] prod_ff, prod_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;
   logic signed [LOG_W-1:0] ln_ff, ln_in;

   always_comb begin
      logic [4:0]  k;
      logic [63:0] sq;
      logic [32:0] t;
      logic [5:0]  ks;
      logic signed [35:0] l2;
      logic [35:0] l2_neg;
      logic [34:0] mag;
      logic [63:0] rsum;
      logic [63:0] rsh;
      logic [30:0] mag_out;
      k = '0;
      for (int i = 0; i < PRICE_W; i++) begin
         if (price[i]) k = 5'(i);
      end
      sq       = 64'(m_ff) * 64'(m_ff);
      t        = sq[63:31];
      ks       = 6'({1'b0, k_ff}) - 6'd16;
      l2       = {ks, frac_ff};
      l2_neg   = -l2;
      mag      = l2[35] ? l2_neg[34:0] : l2[34:0];
      rsum     = 64'(prod_ff) + RND_ADD;
      rsh      = rsum >> RND_SH;
      mag_out  = (rsh > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : rsh[30:0];
      state_in = state_ff;
      iter_in  = iter_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      k_in     = k_ff;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      ln_in    = ln_ff;
      case (state_ff)
         L_IDLE: begin
            if (start) begin
               k_in     = k;
               m_in     = price << (5'd31 - k);
               frac_in  = '0;
               iter_in  = '0;
               state_in = L_SQR;
            end
         end
         L_SQR: begin
            // Each squaring doubles the fraction; an overflow past 2 yields a one bit.
            if (t[32]) begin
               m_in    = t[32:1];
               frac_in = {frac_ff[28:0], 1'b1};
            end else begin
               m_in    = t[31:0];
               frac_in = {frac_ff[28:0], 1'b0};
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(ITER_N - 1)) state_in = L_MUL;
         end
         L_MUL: begin
            neg_in   = l2[35];
            prod_in  = 63'(mag) * 63'(LN2_Q28);
            state_in = L_RND;
         end
         L_RND: begin
            ln_in    = neg_ff ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
            done_in  = 1'b1;
            state_in = L_IDLE;
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      iter_ff <= iter_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      k_ff    <= k_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      ln_ff   <= ln_in;
   end

   assign done   = done_ff;
   assign ln_out = ln_ff;

endmodule
`default_nettype wire

FILE: rtl/alrds_front.sv
// Front part: accepts price words, runs the logarithm and keeps the running totals.
// Depends on alrds_pkg and alrds_log_unit.
`timescale 1ns / 1ps
`default_nettype none
module alrds_front #(
   parameter int MAX_LEN       = alrds_pkg::DEF_MAX_LEN,
   parameter int LOG_FRAC_BITS = alrds_pkg::DEF_LOG_FRAC_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire alrds_pkg::req_word_type req_data,
   output logic                        q_push,
   output alrds_pkg::summary_type      q_data,
   input  wire logic                   q_full
);
   import alrds_pkg::*;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_LOG  = 2'd1;
   localparam logic [1:0] F_DIFF = 2'd2;
   localparam logic [1:0] F_ACC  = 2'd3;
   localparam logic [CNT_W-1:0] PC_MAX = CNT_W'(MAX_LEN);

   logic [1:0]              state_ff, state_in;
   logic signed [LOG_W-1:0] prev_log_ff, prev_log_in;
   logic                    prev_ok_ff, prev_ok_in;
   logic [31:0]             prev_x_ff, prev_x_in;
   logic                    have_x_ff, have_x_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQSUM_W-1:0]      sqsum_ff, sqsum_in;
   logic                    ovf_ff, ovf_in;
   logic [CNT_W-1:0]        pcount_ff, pcount_in;
   logic                    last_ff, last_in;
   logic signed [32:0]      d_ff, d_in;
   logic [31:0]             a_ff, a_in;
   logic                    sq_pend_ff, sq_pend_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic                    log_start;
   logic                    log_done;
   logic signed [LOG_W-1:0] log_val;

   alrds_log_unit #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .price  (req_data.price),
      .done   (log_done),
      .ln_out (log_val)
   );

   always_comb begin
      logic               accept;
      logic               over;
      logic               ok;
      logic               finish;
      logic               fin_last;
      logic signed [32:0] r_diff;
      logic signed [32:0] r_neg;
      logic [31:0]        x;
      logic signed [32:0] d;
      logic signed [32:0] d_neg;
      logic [63:0]        sq_full;
      logic [SQSUM_W:0]   tot;
      accept     = (state_ff == F_IDLE) && req_valid && !q_full;
      over       = pcount_ff >= PC_MAX;
      ok         = req_data.price_valid && (req_data.price != '0);
      r_diff     = {log_val[LOG_W-1], log_val} - {prev_log_ff[LOG_W-1], prev_log_ff};
      r_neg      = -r_diff;
      x          = r_diff[32] ? r_neg[31:0] : r_diff[31:0];
      d          = $signed({1'b0, x}) - $signed({1'b0, prev_x_ff});
      d_neg      = -d;
      sq_full    = 64'(a_ff) * 64'(a_ff);
      tot        = {1'b0, sqsum_ff} + (SQSUM_W + 1)'(sq_ff);
      finish     = 1'b0;
      fin_last   = 1'b0;
      log_start  = 1'b0;
      state_in   = state_ff;
      prev_log_in = prev_log_ff;
      prev_ok_in = prev_ok_ff;
      prev_x_in  = prev_x_ff;
      have_x_in  = have_x_ff;
      cnt_in     = cnt_ff;
      sum_in     = sum_ff;
      sqsum_in   = sqsum_ff;
      ovf_in     = ovf_ff;
      pcount_in  = pcount_ff;
      last_in    = last_ff;
      d_in       = d_ff;
      a_in       = a_ff;
      sq_pend_in = 1'b0;
      sq_in      = sq_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               last_in = req_data.last;
               if (over) begin
                  ovf_in   = 1'b1;
                  finish   = 1'b1;
                  fin_last = req_data.last;
               end else begin
                  pcount_in = pcount_ff + 1'b1;
                  if (ok) begin
                     log_start = 1'b1;
                     state_in  = F_LOG;
                  end else begin
                     prev_ok_in = 1'b0;
                     finish     = 1'b1;
                     fin_last   = req_data.last;
                  end
               end
            end
         end
         F_LOG: begin
            if (log_done) state_in = F_DIFF;
         end
         F_DIFF: begin
            prev_log_in = log_val;
            prev_ok_in  = 1'b1;
            if (prev_ok_ff) begin
               prev_x_in = x;
               have_x_in = 1'b1;
            end
            if (prev_ok_ff && have_x_ff) begin
               d_in       = d;
               a_in       = d[32] ? d_neg[31:0] : d[31:0];
               sq_pend_in = 1'b1;
               state_in   = F_ACC;
            end else begin
               finish   = 1'b1;
               fin_last = last_ff;
            end
         end
         F_ACC: begin
            // This state first registers the square in sq_ff, then adds it into the totals.
            if (sq_pend_ff) begin
               sq_in = sq_full[63:SQ_DROP];
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               sum_in   = sum_ff + SUM_W'(d_ff);
               sqsum_in = tot[SQSUM_W] ? '1 : tot[SQSUM_W-1:0];
               finish   = 1'b1;
               fin_last = last_ff;
            end
         end
         default: state_in = F_IDLE;
      endcase
      q_data.cnt   = cnt_in;
      q_data.sum   = sum_in;
      q_data.sqsum = sqsum_in;
      q_data.ovf   = ovf_in;
      q_push       = finish && fin_last;
      if (finish) state_in = F_IDLE;
      if (q_push) begin
         prev_log_in = '0;
         prev_ok_in  = 1'b0;
         prev_x_in   = '0;
         have_x_in   = 1'b0;
         cnt_in      = '0;
         sum_in      = '0;
         sqsum_in    = '0;
         ovf_in      = 1'b0;
         pcount_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         prev_log_ff <= '0;
         prev_ok_ff  <= 1'b0;
         prev_x_ff   <= '0;
         have_x_ff   <= 1'b0;
         cnt_ff      <= '0;
         sum_ff      <= '0;
         sqsum_ff    <= '0;
         ovf_ff      <= 1'b0;
         pcount_ff   <= '0;
         sq_pend_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         prev_log_ff <= prev_log_in;
         prev_ok_ff  <= prev_ok_in;
         prev_x_ff   <= prev_x_in;
         have_x_ff   <= have_x_in;
         cnt_ff      <= cnt_in;
         sum_ff      <= sum_in;
         sqsum_ff    <= sqsum_in;
         ovf_ff      <= ovf_in;
         pcount_ff   <= pcount_in;
         sq_pend_ff  <= sq_pend_in;
      end
      last_ff <= last_in;
      d_ff    <= d_in;
      a_ff    <= a_in;
      sq_ff   <= sq_in;
   end

   assign req_ready = (state_ff == F_IDLE) && !q_full;

endmodule
`default_nettype wire

FILE: rtl/alrds_fifo.sv
// Two-entry queue of series totals between the front and the back part.
// Depends on alrds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module alrds_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire alrds_pkg::summary_type push_data,
   input  wire logic                   pop,
   output alrds_pkg::summary_type      pop_data,
   output logic                        full,
   output logic                        empty
);
   import alrds_pkg::*;

   localparam int DEPTH = 2;

   summary_type entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign full     = level_ff == 2'(DEPTH);
   assign empty    = level_ff == '0;

endmodule
`default_nettype wire

FILE: rtl/alrds_back.sv
// Back part: turns series totals into a standard deviation with a shared
// multiplier, a bit-serial divider and a bit-serial square root. Depends on alrds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module alrds_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_empty,
   output logic                        q_pop,
   input  wire alrds_pkg::summary_type q_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output alrds_pkg::rsp_word_type     rsp_data
);
   import alrds_pkg::*;

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_MUL  = 3'd1;
   localparam logic [2:0] B_DIV  = 3'd2;
   localparam logic [2:0] B_NORM = 3'd3;
   localparam logic [2:0] B_SQRT = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [MAG_W-1:0]   s1_ff, s1_in;
   logic [SQSUM_W-1:0] sqsum_ff, sqsum_in;
   logic               ovf_ff, ovf_in;
   logic [5:0]         step_ff, step_in;
   logic [63:0]        acc_ff, acc_in;
   logic               phase_ff, phase_in;
   logic [SQSUM_W-1:0] dq_ff, dq_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   dvsr_ff, dvsr_in;
   logic [63:0]        var_ff, var_in;
   logic [3:0]         shift_ff, shift_in;
   logic [63:0]        root_ff, root_in;
   logic [63:0]        bit_ff, bit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_ff, rsp_in;

   always_comb begin
      logic signed [SUM_W-1:0] sum_neg;
      logic [HALF_W-1:0]  lo;
      logic [HALF_W-1:0]  hi;
      logic [HALF_W-1:0]  op_a;
      logic [HALF_W-1:0]  op_b;
      logic [2*HALF_W-1:0] prod;
      logic [63:0]        part;
      logic [CNT_W:0]     trial;
      logic               ge;
      logic [SQSUM_W-1:0] quot;
      logic [63:0]        trial_r;
      logic [38:0]        res;
      sum_neg  = -q_data.sum;
      lo       = s1_ff[HALF_W-1:0];
      hi       = HALF_W'(s1_ff[MAG_W-1:HALF_W]);
      op_a     = (step_ff == 6'd0) ? lo : hi;
      op_b     = (step_ff == 6'd2) ? hi : lo;
      prod     = (2*HALF_W)'(op_a) * (2*HALF_W)'(op_b);
      part     = 64'(prod);
      if (step_ff == 6'd1) part = 64'(prod) << (HALF_W + 1);
      if (step_ff == 6'd2) part = 64'(prod) << (2 * HALF_W);
      trial    = {rem_ff, dq_ff[SQSUM_W-1]};
      ge       = trial >= {1'b0, dvsr_ff};
      quot     = {dq_ff[SQSUM_W-2:0], ge};
      trial_r  = root_ff + bit_ff;
      res      = '0;
      q_pop        = 1'b0;
      state_in     = state_ff;
      n_in         = n_ff;
      s1_in        = s1_ff;
      sqsum_in     = sqsum_ff;
      ovf_in       = ovf_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      phase_in     = phase_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      dvsr_in      = dvsr_ff;
      var_in       = var_ff;
      shift_in     = shift_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty && !rsp_valid_ff) begin
               q_pop = 1'b1;
               if (q_data.cnt < CNT_W'(MIN_DIFFS)) begin
                  rsp_in.std_dev  = '0;
                  rsp_in.defined  = 1'b0;
                  rsp_in.overflow = q_data.ovf;
                  rsp_valid_in    = 1'b1;
               end else begin
                  n_in     = q_data.cnt;
                  s1_in    = q_data.sum[SUM_W-1] ? sum_neg[MAG_W-1:0]
                                                 : q_data.sum[MAG_W-1:0];
                  sqsum_in = q_data.sqsum;
                  ovf_in   = q_data.ovf;
                  acc_in   = '0;
                  step_in  = '0;
                  state_in = B_MUL;
               end
            end
         end
         B_MUL: begin
            // Low 64 bits of the squared sum, built from three half-width products.
            acc_in  = acc_ff + part;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd2) begin
               dq_in    = SQSUM_W'(acc_in[63:SQ_DROP]);
               rem_in   = '0;
               dvsr_in  = n_ff;
               phase_in = 1'b0;
               step_in  = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            rem_in  = ge ? CNT_W'(trial - {1'b0, dvsr_ff}) : trial[CNT_W-1:0];
            dq_in   = quot;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(SQSUM_W - 1)) begin
               step_in = '0;
               if (!phase_ff) begin
                  dq_in    = (sqsum_ff > quot) ? sqsum_ff - quot : '0;
                  rem_in   = '0;
                  dvsr_in  = n_ff - 1'b1;
                  phase_in = 1'b1;
               end else begin
                  var_in   = 64'(quot);
                  shift_in = 4'(SQ_DROP);
                  state_in = B_NORM;
               end
            end
         end
         B_NORM: begin
            if (shift_ff != '0 && !(|var_ff[63:60])) begin
               var_in   = var_ff << 2;
               shift_in = shift_ff - 4'd2;
            end else begin
               root_in  = '0;
               bit_in   = 64'(1) << 62;
               step_in  = '0;
               state_in = B_SQRT;
            end
         end
         B_SQRT: begin
            if (var_ff >= trial_r) begin
               var_in  = var_ff - trial_r;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd31) begin
               res             = {7'd0, root_in[31:0]} << shift_ff[3:1];
               rsp_in.std_dev  = (|res[38:32]) ? '1 : res[31:0];
               rsp_in.defined  = 1'b1;
               rsp_in.overflow = ovf_ff;
               rsp_valid_in    = 1'b1;
               state_in        = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff     <= n_in;
      s1_ff    <= s1_in;
      sqsum_ff <= sqsum_in;
      ovf_ff   <= ovf_in;
      step_ff  <= step_in;
      acc_ff   <= acc_in;
      phase_ff <= phase_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      dvsr_ff  <= dvsr_in;
      var_ff   <= var_in;
      shift_ff <= shift_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

FILE: rtl/abs_log_return_diff_stddev.sv
// Sample standard deviation of differences of absolute log returns over a price
// series. A price that is invalid, zero or beyond MAX_LEN skips the logarithm; a
// good price waits for the logarithm, which does one 32-bit squaring per cycle for
// 30 fraction bits. On the word flagged last the series totals enter a two-entry
// queue, and the back part works through each series (three products, two serial
// divisions, up to seven normalize steps and a square root) while the front
// already takes the next series.
// Depends on alrds_pkg, alrds_front, alrds_fifo, alrds_back and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module abs_log_return_diff_stddev #(
   parameter int MAX_LEN       = alrds_pkg::DEF_MAX_LEN,
   parameter int LOG_FRAC_BITS = alrds_pkg::DEF_LOG_FRAC_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire alrds_pkg::req_word_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output alrds_pkg::rsp_word_type     rsp_data
);
   import alrds_pkg::*;

   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_empty;
   summary_type q_in;
   summary_type q_out;

   alrds_front #(.MAX_LEN(MAX_LEN), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_data    (q_in),
      .q_full    (q_full)
   );

   alrds_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   alrds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_out),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `ASSERT_ALWAYS(a_no_push_full, clock, reset, !(q_push && q_full), "push into full queue")
   `ASSERT_ALWAYS(a_no_pop_empty, clock, reset, !(q_pop && q_empty), "pop from empty queue")
   `ASSERT_IMPLIES(a_undef_zero, clock, reset, rsp_valid && !rsp_data.defined, rsp_data.std_dev == '0, "undefined result not zero")

endmodule
`default_nettype wire

FILE: test/abs_log_return_diff_stddev_tb.sv
// Self-checking testbench for abs_log_return_diff_stddev: price series go in
// through a randomly idling driver, and each series deviation is predicted here.
// Depends on alrds_pkg and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none
module abs_log_return_diff_stddev_tb;
   import alrds_pkg::*;

   localparam int SERIES_MAX   = 4096;
   localparam int FRAC_BITS    = 24;
   localparam longint unsigned SQSUM_LIMIT = 64'hFF_FFFF_FFFF_FFFF;
   localparam int STALL_LIMIT  = 20000;
   localparam int LONG_HOLD    = 3000;
   localparam int DRAIN_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_data;

   req_word_type price_queue[$];
   rsp_word_type deviation_queue[$];
   int send_idle_pct = 27;
   int recv_idle_pct = 69;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   // Predictor state for the running series.
   longint prev_ln;
   bit prev_ok;
   longint unsigned prev_ret;
   bit have_ret;
   int n_diffs;
   longint diff_total;
   longint unsigned square_total;
   bit too_long;
   int n_prices;

   abs_log_return_diff_stddev uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   function automatic longint ln_q(input logic [31:0] p);
      int k;
      longint unsigned m, frac, mag;
      longint l2;
      bit neg;
      k = 31;
      frac = 0;
      while (k > 0 && p[k] == 1'b0) k--;
      m = longint'(p) << (31 - k);
      for (int i = 0; i < 30; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      l2 = longint'(k - 16) * (64'sd1 <<< 30) + longint'(frac);
      neg = l2 < 0;
      mag = neg ? longint'(-l2) : l2;
      mag = mag * 64'd186065280;
      mag = (mag + (64'd1 << (57 - FRAC_BITS))) >> (58 - FRAC_BITS);
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic clear_series();
      prev_ln = 0; prev_ok = 0; prev_ret = 0; have_ret = 0;
      n_diffs = 0; diff_total = 0; square_total = 0; too_long = 0; n_prices = 0;
   endtask

   task automatic take_price(input req_word_type w);
      bit ok;
      longint lp, r, d;
      longint unsigned x, a, sq, n, s1, c, num, var_q, sd;
      int s;
      rsp_word_type res;
      ok = w.price_valid && w.price != 0;
      if (n_prices >= SERIES_MAX) begin
         too_long = 1;
      end else begin
         n_prices++;
         if (ok) begin
            lp = ln_q(w.price);
            if (prev_ok) begin
               r = lp - prev_ln;
               x = r < 0 ? -r : r;
               if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
               if (have_ret) begin
                  d = longint'(x) - longint'(prev_ret);
                  a = d < 0 ? -d : d;
                  sq = (a * a) >> SQ_DROP;
                  n_diffs++;
                  diff_total += d;
                  if (sq > SQSUM_LIMIT - square_total) square_total = SQSUM_LIMIT;
                  else square_total += sq;
               end
               prev_ret = x;
               have_ret = 1;
            end
            prev_ln = lp;
         end
         prev_ok = ok;
      end
      if (w.last) begin
         sd = 0;
         if (n_diffs >= MIN_DIFFS) begin
            n = n_diffs;
            s1 = diff_total < 0 ? -diff_total : diff_total;
            c = ((s1 * s1) >> SQ_DROP) / n;
            num = square_total > c ? square_total - c : 0;
            var_q = num / (n - 1);
            s = SQ_DROP;
            while (s > 0 && var_q < (64'd1 << 60)) begin
               var_q = var_q << 2;
               s -= 2;
            end
            sd = floor_sqrt(var_q) << (s / 2);
            if (sd > 64'hFFFF_FFFF) sd = 64'hFFFF_FFFF;
         end
         res.std_dev = sd[31:0];
         res.defined = n_diffs >= MIN_DIFFS;
         res.overflow = too_long;
         deviation_queue = {deviation_queue, res};
         clear_series();
      end
   endtask

   // Driver: a word stays on the bus until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) take_price(req_data);
         if (!req_valid || req_ready) begin
            if (price_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= price_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor and receiver stalls.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (deviation_queue.size() == 0) begin
               $display("%0t: unexpected word %h", $time, rsp_data);
               error_count++;
            end else begin
               if (rsp_data.std_dev !== deviation_queue[0].std_dev ||
                   rsp_data.defined !== deviation_queue[0].defined ||
                   rsp_data.overflow !== deviation_queue[0].overflow) begin
                  $display("%0t: expected %h actual %h", $time, deviation_queue[0],
                           rsp_data);
                  error_count++;
               end
               void'(deviation_queue.pop_front());
            end
         end
      end
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(0, 99) >= recv_idle_pct;
      end
   end

   // Watchdog on cycles with no accepted word on either side.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[abs_log_return_diff_stddev] ERROR");
         $finish;
      end
   end

   task automatic push_price(input logic [31:0] p, input bit v, input bit l);
      req_word_type w;
      w.price = p;
      w.price_valid = v;
      w.last = l;
      price_queue = {price_queue, w};
   endtask

   // One series of the given length; prices mostly wander near a base value.
   task automatic push_series(input int len);
      logic [31:0] base, p;
      int pick;
      base = $urandom_range(16, 32'hF000_0000) >> $urandom_range(0, 24);
      if (base == 0) base = 1;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) p = $urandom();
         else if (pick < 8) p = 0;
         else p = base + $urandom_range(0, base >> $urandom_range(1, 8));
         push_price(p, $urandom_range(0, 99) >= 6, i == len - 1);
      end
   endtask

   task automatic wait_drained();
      while (price_queue.size() > 0 || req_valid || deviation_queue.size() > 0)
         @(posedge clock);
   endtask

   task automatic random_part(input int items);
      int sent;
      sent = 0;
      while (sent < items) begin
         int len;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
         push_series(len);
         sent += len;
      end
   endtask

   initial begin
      clear_series();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed series: extremes, unit price, invalid and zero prices.
      push_price(32'h0001_0000, 1, 1);
      push_price(32'h0000_0001, 1, 0);
      push_price(32'hFFFF_FFFF, 1, 0);
      push_price(32'h0000_0001, 1, 0);
      push_price(32'hFFFF_FFFF, 1, 0);
      push_price(32'h0000_0001, 1, 1);
      push_price(32'h0002_0000, 1, 0);
      push_price(32'h0000_0000, 1, 0);
      push_price(32'h0003_0000, 0, 0);
      push_price(32'h0004_0000, 1, 0);
      push_price(32'h0008_0000, 1, 0);
      push_price(32'h0001_0000, 1, 1);
      for (int i = 0; i < 6; i++) push_price(32'h1234_5678, 1, i == 5);
      push_price(32'h0001_0000, 1, 0);
      push_price(32'h0002_0000, 1, 0);
      push_price(32'h0001_0000, 1, 0);
      push_price(32'h0002_0000, 1, 1);
      push_price(32'h0000_0000, 0, 1);

      // The receiver holds off while the sender keeps the block full.
      hold_requests = hold_requests + 1;
      random_part(330);
      wait_drained();
      // Sender pause with everything drained.
      repeat (200) @(posedge clock);

      send_idle_pct = 69;
      recv_idle_pct = 27;
      random_part(340);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_part(340);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) $display("[abs_log_return_diff_stddev] OK");
      else $display("[abs_log_return_diff_stddev] ERROR");
      $finish;
   end
endmodule
`default_nettype wire
